// ===== rtl/cvm_pkg.sv =====
// Shared types, constants and the Q15 sine table of the chassis velocity mixer.
package cvm_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SPEED_WIDTH      = 16;

    localparam int OUT_W    = SPEED_WIDTH + 2;
    localparam int MODE_W   = 3;
    localparam int SPIN_W   = 17;
    localparam int ANGLE_W  = 13;
    localparam int GAIN_W   = 16;
    localparam int FACTOR_W = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam int QUARTER_TURN = 1440;
    localparam int FULL_TURN    = 4 * QUARTER_TURN;
    localparam int TURN_W       = $clog2(FULL_TURN);
    localparam int REM_W        = $clog2(QUARTER_TURN);

    localparam int SINE_W = 16;
    localparam int TRIG_W = SINE_W + 1;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);

    // a * |a| and the follow-mode product
    localparam int SQ_W    = 2 * ANGLE_W - 1;
    localparam int FPROD_W = SQ_W + GAIN_W + 1;
    localparam int W_W     = FPROD_W - 16;

    localparam int QUEUE_DEPTH = 4;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [MODE_W-1:0] MODE_ZERO_FORCE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NO_FOLLOW  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FOLLOW     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROTATE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FREE_SPIN  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_RATE    = 2'd2;

    localparam logic [FACTOR_W-1:0]      RST_WHEEL_FACTOR = 16'd32768;
    localparam logic [GAIN_W-1:0]        RST_FOLLOW_GAIN  = 16'd384;
    localparam logic signed [SPIN_W-1:0] RST_SPIN_RATE    = 17'sd4000;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        SPIN_ZERO,
        SPIN_FOLLOW,
        SPIN_FIXED,
        SPIN_CMD
    } t_spin_src;

    typedef struct packed {
        logic [1:0]       quad;
        logic [REM_W-1:0] rem;
    } t_trig_pos;

    typedef struct packed {
        t_spin_src                     spin_src;
        logic                          motors_en;
        logic signed [SPEED_WIDTH-1:0] fwd;
        logic signed [SPEED_WIDTH-1:0] lat;
        logic signed [SPIN_W-1:0]      spin_cmd;
        logic signed [SQ_W-1:0]        asq;
        t_trig_pos                     sin_pos;
        t_trig_pos                     cos_pos;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic [FACTOR_W-1:0]      wheel_factor;
        logic [GAIN_W-1:0]        follow_gain;
        logic signed [SPIN_W-1:0] spin_rate;
    } t_cfg;

    typedef logic [SINE_W-1:0] t_sine_tab [SINE_TABLE_DEPTH+1];

    // Q30 Taylor series to x^17, rounded to Q15 half up
    function automatic t_sine_tab f_sine_tab();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            q = (sum + 64'sd16384) >>> 15;
            if (q > 32768) begin
                q = 32768;
            end
            tab[k] = SINE_W'(q);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_sine_tab();

    // exact reciprocal of the quarter turn for the table index
    localparam int NUM_W = $clog2((QUARTER_TURN - 1) * SINE_TABLE_DEPTH
                                  + QUARTER_TURN / 2 + 1);
    localparam int RECIP_SH = NUM_W + REM_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SH) + 64'(QUARTER_TURN) - 64'd1) / QUARTER_TURN;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PIDX_W  = RECIP_SH + IDX_W;

endpackage

// ===== rtl/cvm_if.sv =====
// Request channels of the chassis velocity mixer: drive commands in, wheel references out.
interface cvm_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [cvm_pkg::MODE_W-1:0]             mode;
    logic signed [cvm_pkg::SPEED_WIDTH-1:0] forward_speed;
    logic signed [cvm_pkg::SPEED_WIDTH-1:0] lateral_speed;
    logic signed [cvm_pkg::SPIN_W-1:0]      spin_command;
    logic signed [cvm_pkg::ANGLE_W-1:0]     gimbal_angle;

    modport source (output valid, mode, forward_speed, lateral_speed, spin_command,
                    gimbal_angle, input ready);
    modport sink (input valid, mode, forward_speed, lateral_speed, spin_command,
                  gimbal_angle, output ready);
endinterface

interface cvm_ref_if;
    logic                             valid;
    logic                             ready;
    logic signed [cvm_pkg::OUT_W-1:0] front_left_ref;
    logic signed [cvm_pkg::OUT_W-1:0] front_right_ref;
    logic signed [cvm_pkg::OUT_W-1:0] back_left_ref;
    logic signed [cvm_pkg::OUT_W-1:0] back_right_ref;
    logic                             motors_enabled;
    logic                             clipped;

    modport source (output valid, front_left_ref, front_right_ref, back_left_ref,
                    back_right_ref, motors_enabled, clipped, input ready);
    modport sink (input valid, front_left_ref, front_right_ref, back_left_ref,
                  back_right_ref, motors_enabled, clipped, output ready);
endinterface

// ===== rtl/cvm_front.sv =====
// Front end: accepts drive commands, decodes the mode and splits the angle into quadrants.
module cvm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cvm_cmd_if.sink              i_cmd,
    input  cvm_pkg::t_queue_stat i_stat,
    output logic                 o_push,
    output cvm_pkg::t_cmd        o_cmd
);

    logic          r_vld;
    cvm_pkg::t_cmd r_cmd;
    cvm_pkg::t_cmd n_cmd;

    logic                                 accept;
    logic [cvm_pkg::ANGLE_W-1:0]          mag;
    logic signed [cvm_pkg::ANGLE_W:0]     ang_s;
    logic signed [cvm_pkg::ANGLE_W:0]     ang_c;

    function automatic cvm_pkg::t_trig_pos f_split(input logic signed [cvm_pkg::ANGLE_W:0] v);
        cvm_pkg::t_trig_pos          p;
        logic [cvm_pkg::TURN_W-1:0] u;
        if (v < 0) begin
            u = cvm_pkg::TURN_W'(v + cvm_pkg::FULL_TURN);
        end else begin
            u = cvm_pkg::TURN_W'(v);
        end
        if (u >= cvm_pkg::TURN_W'(3 * cvm_pkg::QUARTER_TURN)) begin
            p.quad = 2'd3;
            p.rem  = cvm_pkg::REM_W'(u - cvm_pkg::TURN_W'(3 * cvm_pkg::QUARTER_TURN));
        end else if (u >= cvm_pkg::TURN_W'(2 * cvm_pkg::QUARTER_TURN)) begin
            p.quad = 2'd2;
            p.rem  = cvm_pkg::REM_W'(u - cvm_pkg::TURN_W'(2 * cvm_pkg::QUARTER_TURN));
        end else if (u >= cvm_pkg::TURN_W'(cvm_pkg::QUARTER_TURN)) begin
            p.quad = 2'd1;
            p.rem  = cvm_pkg::REM_W'(u - cvm_pkg::TURN_W'(cvm_pkg::QUARTER_TURN));
        end else begin
            p.quad = 2'd0;
            p.rem  = cvm_pkg::REM_W'(u);
        end
        return p;
    endfunction

    // hold the register while the queue is full
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_vld || !i_stat.full;
    assign o_push      = r_vld && !i_stat.full;
    assign o_cmd       = r_cmd;

    always_comb begin
        mag   = i_cmd.gimbal_angle[cvm_pkg::ANGLE_W-1] ?
                cvm_pkg::ANGLE_W'(-i_cmd.gimbal_angle) : cvm_pkg::ANGLE_W'(i_cmd.gimbal_angle);
        ang_s = {i_cmd.gimbal_angle[cvm_pkg::ANGLE_W-1], i_cmd.gimbal_angle};
        ang_c = ang_s + (cvm_pkg::ANGLE_W+1)'(cvm_pkg::QUARTER_TURN);

        n_cmd.fwd      = i_cmd.forward_speed;
        n_cmd.lat      = i_cmd.lateral_speed;
        n_cmd.spin_cmd = i_cmd.spin_command;
        n_cmd.asq      = i_cmd.gimbal_angle * $signed({1'b0, mag});
        n_cmd.sin_pos  = f_split(ang_s);
        n_cmd.cos_pos  = f_split(ang_c);

        n_cmd.motors_en = 1'b1;
        case (i_cmd.mode)
            cvm_pkg::MODE_ZERO_FORCE: begin
                n_cmd.spin_src  = cvm_pkg::SPIN_CMD;
                n_cmd.motors_en = 1'b0;
            end
            cvm_pkg::MODE_NO_FOLLOW: n_cmd.spin_src = cvm_pkg::SPIN_ZERO;
            cvm_pkg::MODE_FOLLOW:    n_cmd.spin_src = cvm_pkg::SPIN_FOLLOW;
            cvm_pkg::MODE_ROTATE:    n_cmd.spin_src = cvm_pkg::SPIN_FIXED;
            cvm_pkg::MODE_FREE_SPIN: n_cmd.spin_src = cvm_pkg::SPIN_CMD;
            // unknown modes spin freely
            default:                 n_cmd.spin_src = cvm_pkg::SPIN_CMD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/cvm_queue.sv =====
// Short command queue between the front end and the mixing pipeline.
module cvm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cvm_pkg::t_cmd        i_push_data,
    input  logic                 i_pop,
    output cvm_pkg::t_cmd        o_pop_data,
    output cvm_pkg::t_queue_stat o_stat
);

    localparam int PTR_W = $clog2(cvm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cvm_pkg::QUEUE_DEPTH + 1);

    cvm_pkg::t_cmd    r_mem [cvm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(cvm_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_stat.full  = (r_count == CNT_W'(cvm_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/cvm_back.sv =====
// Mixing pipeline: spin rate, sine lookup, frame rotation, wheel mix, scale and saturation.
module cvm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cvm_pkg::t_cfg        i_cfg,
    input  cvm_pkg::t_queue_stat i_stat,
    input  cvm_pkg::t_cmd        i_cmd,
    output logic                 o_pop,
    cvm_ref_if.source            o_ref
);

    localparam int NSTAGE = 7;
    localparam int SW     = cvm_pkg::SPEED_WIDTH;
    localparam int PROD_W = SW + cvm_pkg::TRIG_W;
    localparam int V_W    = SW + 2;
    localparam int MIX_W  = V_W + 1;
    localparam int MK_W   = MIX_W + cvm_pkg::FACTOR_W + 1;
    localparam int R_W    = MK_W - 15;
    localparam int SUM_W  = ((R_W > cvm_pkg::W_W) ? R_W : cvm_pkg::W_W) + 1;

    logic                      en;
    logic [NSTAGE-1:0]         r_vld;

    // stage 0: index reciprocal products and follow product
    logic [cvm_pkg::NUM_W-1:0]  num_s;
    logic [cvm_pkg::NUM_W-1:0]  num_c;
    logic [cvm_pkg::PIDX_W-1:0] r0_pidx_s;
    logic [cvm_pkg::PIDX_W-1:0] r0_pidx_c;
    logic [1:0]                 r0_quad_s;
    logic [1:0]                 r0_quad_c;
    logic signed [cvm_pkg::FPROD_W-1:0] r0_fprod;
    cvm_pkg::t_spin_src         r0_spin_src;
    logic signed [cvm_pkg::SPIN_W-1:0]  r0_spin_cmd;
    logic signed [SW-1:0]       r0_fwd;
    logic signed [SW-1:0]       r0_lat;
    logic                       r0_men;

    // stage 1: sine, cosine and spin rate
    logic signed [cvm_pkg::FPROD_W:0]  fp_rnd;
    logic signed [cvm_pkg::W_W-1:0]    n_w;
    logic signed [cvm_pkg::TRIG_W-1:0] r1_s;
    logic signed [cvm_pkg::TRIG_W-1:0] r1_c;
    logic signed [cvm_pkg::W_W-1:0]    r1_w;
    logic signed [SW-1:0]              r1_fwd;
    logic signed [SW-1:0]              r1_lat;
    logic                              r1_men;

    // stage 2: rotation products
    logic signed [PROD_W-1:0]       r2_fc;
    logic signed [PROD_W-1:0]       r2_ls;
    logic signed [PROD_W-1:0]       r2_fs;
    logic signed [PROD_W-1:0]       r2_lc;
    logic signed [cvm_pkg::W_W-1:0] r2_w;
    logic                           r2_men;

    // stage 3: rotated speeds
    logic signed [PROD_W:0]         dx;
    logic signed [PROD_W:0]         dy;
    logic signed [V_W-1:0]          r3_vx;
    logic signed [V_W-1:0]          r3_vy;
    logic signed [cvm_pkg::W_W-1:0] r3_w;
    logic                           r3_men;

    // stage 4: wheel sign matrix
    logic signed [MIX_W-1:0]        r4_mix [4];
    logic signed [cvm_pkg::W_W-1:0] r4_w;
    logic                           r4_men;

    // stage 5: wheel factor scaling
    logic signed [cvm_pkg::FACTOR_W:0] k;
    logic signed [MK_W-1:0]            r5_mk [4];
    logic signed [cvm_pkg::W_W-1:0]    r5_w;
    logic                              r5_men;

    // stage 6: output register
    logic signed [MK_W-1:0]           mk_rnd [4];
    logic signed [SUM_W-1:0]          tot [4];
    logic signed [cvm_pkg::OUT_W-1:0] n_ref [4];
    logic [3:0]                       n_clip;
    logic signed [cvm_pkg::OUT_W-1:0] r6_ref [4];
    logic                             r6_men;
    logic                             r6_clip;

    function automatic logic signed [cvm_pkg::TRIG_W-1:0] f_trig(
        input logic [cvm_pkg::PIDX_W-1:0] pidx,
        input logic [1:0]                 quad
    );
        logic [cvm_pkg::IDX_W-1:0]  idx;
        logic [cvm_pkg::IDX_W-1:0]  addr;
        logic [cvm_pkg::SINE_W-1:0] val;
        idx = pidx[cvm_pkg::RECIP_SH +: cvm_pkg::IDX_W];
        // odd quadrants read the table backwards
        addr = quad[0] ? cvm_pkg::IDX_W'(cvm_pkg::SINE_TABLE_DEPTH) - idx : idx;
        val = cvm_pkg::SINE_TAB[addr];
        if (quad[1]) begin
            return -$signed({1'b0, val});
        end
        return $signed({1'b0, val});
    endfunction

    assign en    = !r_vld[NSTAGE-1] || o_ref.ready;
    assign o_pop = en && !i_stat.empty;

    assign k = $signed({1'b0, i_cfg.wheel_factor});

    always_comb begin
        num_s = cvm_pkg::NUM_W'(i_cmd.sin_pos.rem) * cvm_pkg::NUM_W'(cvm_pkg::SINE_TABLE_DEPTH)
                + cvm_pkg::NUM_W'(cvm_pkg::QUARTER_TURN / 2);
        num_c = cvm_pkg::NUM_W'(i_cmd.cos_pos.rem) * cvm_pkg::NUM_W'(cvm_pkg::SINE_TABLE_DEPTH)
                + cvm_pkg::NUM_W'(cvm_pkg::QUARTER_TURN / 2);

        // round the follow product to nearest, ties away from zero, then negate
        fp_rnd = r0_fprod + (cvm_pkg::FPROD_W+1)'(1 << 15)
                 - (cvm_pkg::FPROD_W+1)'(r0_fprod[cvm_pkg::FPROD_W-1]);
        case (r0_spin_src)
            cvm_pkg::SPIN_ZERO:   n_w = '0;
            cvm_pkg::SPIN_FOLLOW: n_w = -fp_rnd[16 +: cvm_pkg::W_W];
            cvm_pkg::SPIN_FIXED:  n_w = cvm_pkg::W_W'(i_cfg.spin_rate);
            cvm_pkg::SPIN_CMD:    n_w = cvm_pkg::W_W'(r0_spin_cmd);
            default:              n_w = cvm_pkg::W_W'(r0_spin_cmd);
        endcase

        dx = r2_fc - r2_ls;
        dy = r2_fs + r2_lc;
        dx = dx + (PROD_W+1)'(1 << 14) - (PROD_W+1)'(dx[PROD_W]);
        dy = dy + (PROD_W+1)'(1 << 14) - (PROD_W+1)'(dy[PROD_W]);

        for (int i = 0; i < 4; i++) begin
            mk_rnd[i] = r5_mk[i] + MK_W'(1 << 14) - MK_W'(r5_mk[i][MK_W-1]);
            tot[i]    = SUM_W'($signed(mk_rnd[i][15 +: R_W])) - SUM_W'(r5_w);
            // saturate when the bits above the output width disagree with its sign
            if ((&tot[i][SUM_W-1:cvm_pkg::OUT_W-1]) || !(|tot[i][SUM_W-1:cvm_pkg::OUT_W-1]))
            begin
                n_ref[i]  = tot[i][cvm_pkg::OUT_W-1:0];
                n_clip[i] = 1'b0;
            end else begin
                n_ref[i]  = tot[i][SUM_W-1] ? cvm_pkg::OUT_MIN : cvm_pkg::OUT_MAX;
                n_clip[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_pidx_s   <= cvm_pkg::PIDX_W'(num_s) * cvm_pkg::PIDX_W'(cvm_pkg::RECIP);
            r0_pidx_c   <= cvm_pkg::PIDX_W'(num_c) * cvm_pkg::PIDX_W'(cvm_pkg::RECIP);
            r0_quad_s   <= i_cmd.sin_pos.quad;
            r0_quad_c   <= i_cmd.cos_pos.quad;
            r0_fprod    <= $signed({1'b0, i_cfg.follow_gain}) * i_cmd.asq;
            r0_spin_src <= i_cmd.spin_src;
            r0_spin_cmd <= i_cmd.spin_cmd;
            r0_fwd      <= i_cmd.fwd;
            r0_lat      <= i_cmd.lat;
            r0_men      <= i_cmd.motors_en;

            r1_s   <= f_trig(r0_pidx_s, r0_quad_s);
            r1_c   <= f_trig(r0_pidx_c, r0_quad_c);
            r1_w   <= n_w;
            r1_fwd <= r0_fwd;
            r1_lat <= r0_lat;
            r1_men <= r0_men;

            r2_fc  <= r1_fwd * r1_c;
            r2_ls  <= r1_lat * r1_s;
            r2_fs  <= r1_fwd * r1_s;
            r2_lc  <= r1_lat * r1_c;
            r2_w   <= r1_w;
            r2_men <= r1_men;

            r3_vx  <= dx[15 +: V_W];
            r3_vy  <= dy[15 +: V_W];
            r3_w   <= r2_w;
            r3_men <= r2_men;

            r4_mix[0] <= -MIX_W'(r3_vx) - MIX_W'(r3_vy);
            r4_mix[1] <= -MIX_W'(r3_vx) + MIX_W'(r3_vy);
            r4_mix[2] <= MIX_W'(r3_vx) - MIX_W'(r3_vy);
            r4_mix[3] <= MIX_W'(r3_vx) + MIX_W'(r3_vy);
            r4_w      <= r3_w;
            r4_men    <= r3_men;

            for (int i = 0; i < 4; i++) begin
                r5_mk[i] <= r4_mix[i] * k;
            end
            r5_w   <= r4_w;
            r5_men <= r4_men;

            r6_ref  <= n_ref;
            r6_clip <= |n_clip;
            r6_men  <= r5_men;
        end
    end

    assign o_ref.valid           = r_vld[NSTAGE-1];
    assign o_ref.front_left_ref  = r6_ref[0];
    assign o_ref.front_right_ref = r6_ref[1];
    assign o_ref.back_left_ref   = r6_ref[2];
    assign o_ref.back_right_ref  = r6_ref[3];
    assign o_ref.motors_enabled  = r6_men;
    assign o_ref.clipped         = r6_clip;

endmodule

// ===== rtl/chassis_velocity_mixer.sv =====
// Chassis velocity mixer top level: configuration registers, front end, queue and pipeline.
//
// Turns each drive command into four saturated mecanum/omni wheel speed references in a
// single pass with no state carried between commands. One command is accepted per clock
// and one result leaves per clock while the output is not stalled. The front-end register
// loads a command on the accepting edge; the command then passes through the four-entry
// command queue and seven pipeline stages. The output register holds a result until it is
// taken; while it waits the queue keeps accepting commands until it and the front-end
// register are full, so input ready drops only after five commands pile up behind a
// stalled output. Write the wheel factor, follow gain and rotate spin rate only while no
// command is in flight.
module chassis_velocity_mixer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cvm_cmd_if.sink                       i_cmd,
    cvm_ref_if.source                     o_ref,
    input  logic                          i_cfg_we,
    input  logic [cvm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cvm_pkg::CFG_W-1:0]     i_cfg_data
);

    cvm_pkg::t_cfg        r_cfg;
    cvm_pkg::t_queue_stat stat;
    cvm_pkg::t_cmd        push_cmd;
    cvm_pkg::t_cmd        pop_cmd;
    logic                 push;
    logic                 pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_factor <= cvm_pkg::RST_WHEEL_FACTOR;
            r_cfg.follow_gain  <= cvm_pkg::RST_FOLLOW_GAIN;
            r_cfg.spin_rate    <= cvm_pkg::RST_SPIN_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cvm_pkg::CFG_WHEEL_FACTOR: r_cfg.wheel_factor <= i_cfg_data[cvm_pkg::FACTOR_W-1:0];
                cvm_pkg::CFG_FOLLOW_GAIN:  r_cfg.follow_gain  <= i_cfg_data[cvm_pkg::GAIN_W-1:0];
                cvm_pkg::CFG_SPIN_RATE:    r_cfg.spin_rate    <= $signed(i_cfg_data);
                // drop writes to unmapped indexes
                default: ;
            endcase
        end
    end

    cvm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    cvm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .i_pop       (pop),
        .o_pop_data  (pop_cmd),
        .o_stat      (stat)
    );

    cvm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_stat  (stat),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_ref   (o_ref)
    );

endmodule

// ===== rtl/cvm_checker.sv =====
// Port-level checks of the chassis velocity mixer and their binding to the top level.
module cvm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [cvm_pkg::OUT_W-1:0] i_fl,
    input logic signed [cvm_pkg::OUT_W-1:0] i_fr,
    input logic signed [cvm_pkg::OUT_W-1:0] i_bl,
    input logic signed [cvm_pkg::OUT_W-1:0] i_br,
    input logic                             i_motors_enabled,
    input logic                             i_clipped
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fl) && $stable(i_fr)
            && $stable(i_bl) && $stable(i_br) && $stable(i_motors_enabled)
            && $stable(i_clipped))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a clipped result has at least one wheel at a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clipped |->
            i_fl == cvm_pkg::OUT_MAX || i_fl == cvm_pkg::OUT_MIN
            || i_fr == cvm_pkg::OUT_MAX || i_fr == cvm_pkg::OUT_MIN
            || i_bl == cvm_pkg::OUT_MAX || i_bl == cvm_pkg::OUT_MIN
            || i_br == cvm_pkg::OUT_MAX || i_br == cvm_pkg::OUT_MIN)
        else $error("clip flag without a saturated wheel");

endmodule

bind chassis_velocity_mixer cvm_checker u_cvm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_ref.valid),
    .i_out_ready      (o_ref.ready),
    .i_fl             (o_ref.front_left_ref),
    .i_fr             (o_ref.front_right_ref),
    .i_bl             (o_ref.back_left_ref),
    .i_br             (o_ref.back_right_ref),
    .i_motors_enabled (o_ref.motors_enabled),
    .i_clipped        (o_ref.clipped)
);

// ===== verif/tb_chassis_velocity_mixer.sv =====
// Self-checking testbench for the chassis velocity mixer: random and directed drive requests.
`timescale 1ns / 1ps

module tb_chassis_velocity_mixer;
    import cvm_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int HALF_TURN       = 2 * QUARTER_TURN;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_LAST_CODE = '1;

    localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = {1'b0, {(SPEED_WIDTH-1){1'b1}}};
    localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
    localparam logic signed [SPIN_W-1:0]      SPIN_MAX  = {1'b0, {(SPIN_W-1){1'b1}}};
    localparam logic signed [SPIN_W-1:0]      SPIN_MIN  = {1'b1, {(SPIN_W-1){1'b0}}};
    localparam logic signed [ANGLE_W-1:0]     ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0]     ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    typedef struct packed {
        logic [MODE_W-1:0]             mode;
        logic signed [SPEED_WIDTH-1:0] fwd;
        logic signed [SPEED_WIDTH-1:0] lat;
        logic signed [SPIN_W-1:0]      spin;
        logic signed [ANGLE_W-1:0]     angle;
    } t_drive_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] fl;
        logic signed [OUT_W-1:0] fr;
        logic signed [OUT_W-1:0] bl;
        logic signed [OUT_W-1:0] br;
        logic                    enabled;
        logic                    clip;
    } t_wheel_ref;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    cvm_cmd_if cmd_if ();
    cvm_ref_if ref_if ();

    chassis_velocity_mixer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_ref      (ref_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // register copies used by the wheel predictor
    logic [FACTOR_W-1:0]      wheel_factor_q15;
    logic [GAIN_W-1:0]        follow_gain_q8;
    logic signed [SPIN_W-1:0] rotate_spin;

    int         sine_lut [0:SINE_TABLE_DEPTH];
    t_drive_req pending_reqs [$];
    t_wheel_ref expected_refs [$];
    t_drive_req next_req;

    int   idle_pct;
    int   src_gap;
    int   sink_gap;
    int   err_cnt;
    int   cycle_cnt;
    logic cmd_fire;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Q15 quarter-wave sine, Q30 Taylor series up to x^17, rounded half up
    function automatic void fill_sine_lut();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          q;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x = (HALF_PI_Q30 * k + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            acc = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            q = (acc + (longint'(1) << 14)) >>> 15;
            if (q > 32768) begin
                q = 32768;
            end
            sine_lut[k] = int'(q);
        end
    endfunction

    // shift right, round to nearest with ties away from zero
    function automatic longint round_shift(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v < 0) begin
            return -((-v + half) >>> s);
        end
        return (v + half) >>> s;
    endfunction

    function automatic longint sine_q15_at(longint a);
        longint u;
        longint quad;
        longint r;
        longint idx;
        longint v;
        u = ((a % FULL_TURN) + FULL_TURN) % FULL_TURN;
        quad = u / QUARTER_TURN;
        r = u % QUARTER_TURN;
        idx = (r * SINE_TABLE_DEPTH + QUARTER_TURN / 2) / QUARTER_TURN;
        if (idx > SINE_TABLE_DEPTH) begin
            idx = SINE_TABLE_DEPTH;
        end
        if (quad == 0 || quad == 2) begin
            v = sine_lut[idx];
        end else begin
            v = sine_lut[SINE_TABLE_DEPTH - idx];
        end
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_ref(longint v, inout logic clip);
        longint hi;
        longint lo;
        hi = (longint'(1) << (OUT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            clip = 1'b1;
            return OUT_MAX;
        end
        if (v < lo) begin
            clip = 1'b1;
            return OUT_MIN;
        end
        return OUT_W'(v);
    endfunction

    function automatic t_wheel_ref predict_wheels(t_drive_req d);
        t_wheel_ref res;
        longint     f;
        longint     l;
        longint     w;
        longint     a;
        longint     mag;
        longint     gain;
        longint     s;
        longint     c;
        longint     vx;
        longint     vy;
        longint     k;
        logic       clip;
        f = d.fwd;
        l = d.lat;
        a = d.angle;
        gain = longint'(follow_gain_q8);
        k = longint'(wheel_factor_q15);
        clip = 1'b0;
        case (d.mode)
            MODE_NO_FOLLOW: begin
                w = 0;
            end
            MODE_FOLLOW: begin
                mag = (a < 0) ? -a : a;
                w = -round_shift(gain * a * mag, 16);
            end
            MODE_ROTATE: begin
                w = rotate_spin;
            end
            default: begin
                w = d.spin;
            end
        endcase
        s = sine_q15_at(a);
        c = sine_q15_at(a + QUARTER_TURN);
        vx = round_shift(f * c - l * s, 15);
        vy = round_shift(f * s + l * c, 15);
        res.fl = clamp_ref(round_shift((-vx - vy) * k, 15) - w, clip);
        res.fr = clamp_ref(round_shift((-vx + vy) * k, 15) - w, clip);
        res.bl = clamp_ref(round_shift((vx - vy) * k, 15) - w, clip);
        res.br = clamp_ref(round_shift((vx + vy) * k, 15) - w, clip);
        res.enabled = (d.mode != MODE_ZERO_FORCE);
        res.clip = clip;
        return res;
    endfunction

    function automatic logic signed [SPEED_WIDTH-1:0] random_speed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            return SPEED_MAX;
        end
        if (pick < 10) begin
            return SPEED_MIN;
        end
        if (pick < 14) begin
            return '0;
        end
        if (pick < 55) begin
            return SPEED_WIDTH'($urandom);
        end
        return SPEED_WIDTH'($urandom_range(4000) - 2000);
    endfunction

    function automatic t_drive_req random_req();
        t_drive_req r;
        if ($urandom_range(99) < 6) begin
            r.mode = MODE_W'($urandom_range(MODE_LAST_CODE, MODE_FREE_SPIN + 1));
        end else begin
            r.mode = MODE_W'($urandom_range(MODE_FREE_SPIN, MODE_ZERO_FORCE));
        end
        r.fwd = random_speed();
        r.lat = random_speed();
        if ($urandom_range(1) == 1) begin
            r.spin = SPIN_W'($urandom);
        end else begin
            r.spin = SPIN_W'($urandom_range(10000) - 5000);
        end
        if ($urandom_range(99) < 85) begin
            r.angle = ANGLE_W'($urandom_range(2 * HALF_TURN) - HALF_TURN);
        end else begin
            r.angle = ANGLE_W'($urandom);
        end
        return r;
    endfunction

    task automatic add_req(input logic [MODE_W-1:0] mode,
                           input logic signed [SPEED_WIDTH-1:0] fwd,
                           input logic signed [SPEED_WIDTH-1:0] lat,
                           input logic signed [SPIN_W-1:0] spin,
                           input logic signed [ANGLE_W-1:0] angle);
        t_drive_req r;
        r.mode = mode;
        r.fwd = fwd;
        r.lat = lat;
        r.spin = spin;
        r.angle = angle;
        pending_reqs.push_back(r);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        case (idx)
            CFG_WHEEL_FACTOR: wheel_factor_q15 = value[FACTOR_W-1:0];
            CFG_FOLLOW_GAIN:  follow_gain_q8 = value[GAIN_W-1:0];
            CFG_SPIN_RATE:    rotate_spin = value[SPIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_reqs.size() != 0 || cmd_if.valid === 1'b1
               || expected_refs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [FACTOR_W-1:0] wf, input logic [GAIN_W-1:0] gain,
                             input logic signed [SPIN_W-1:0] spin, input int idle);
        wait_drain();
        set_reg(CFG_WHEEL_FACTOR, CFG_W'(wf));
        set_reg(CFG_FOLLOW_GAIN, CFG_W'(gain));
        set_reg(CFG_SPIN_RATE, spin);
        // writes to the spare index must leave every register alone
        set_reg(CFG_SPARE_IDX, CFG_W'($urandom));
        idle_pct = idle;
        repeat (ITEMS_PER_PHASE) pending_reqs.push_back(random_req());
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_fire) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && $urandom_range(99) < idle_pct) begin
                src_gap <= $urandom_range(2);
                cmd_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                cmd_if.valid <= 1'b1;
                cmd_if.mode <= next_req.mode;
                cmd_if.forward_speed <= next_req.fwd;
                cmd_if.lateral_speed <= next_req.lat;
                cmd_if.spin_command <= next_req.spin;
                cmd_if.gimbal_angle <= next_req.angle;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            ref_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            ref_if.ready <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
            sink_gap <= $urandom_range(2);
            ref_if.ready <= 1'b0;
        end else begin
            ref_if.ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted request, compare each accepted result
    always @(posedge i_clk) begin
        t_drive_req seen_req;
        t_wheel_ref want;
        cmd_fire = i_rst_n && cmd_if.valid && cmd_if.ready;
        if (cmd_fire) begin
            seen_req.mode = cmd_if.mode;
            seen_req.fwd = cmd_if.forward_speed;
            seen_req.lat = cmd_if.lateral_speed;
            seen_req.spin = cmd_if.spin_command;
            seen_req.angle = cmd_if.gimbal_angle;
            expected_refs.push_back(predict_wheels(seen_req));
        end
        if (i_rst_n && ref_if.valid === 1'b1 && ref_if.ready === 1'b1) begin
            if (expected_refs.size() == 0) begin
                err_cnt++;
                $display("%0t: wheel reference with no request pending", $time);
            end else begin
                want = expected_refs.pop_front();
                check_field("front_left_ref", want.fl, ref_if.front_left_ref);
                check_field("front_right_ref", want.fr, ref_if.front_right_ref);
                check_field("back_left_ref", want.bl, ref_if.back_left_ref);
                check_field("back_right_ref", want.br, ref_if.back_right_ref);
                check_field("motors_enabled", want.enabled, ref_if.motors_enabled);
                check_field("clipped", want.clip, ref_if.clipped);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_WHEEL_FACTOR;
        cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.mode = MODE_ZERO_FORCE;
        cmd_if.forward_speed = '0;
        cmd_if.lateral_speed = '0;
        cmd_if.spin_command = '0;
        cmd_if.gimbal_angle = '0;
        ref_if.ready = 1'b0;
        cmd_fire = 1'b0;
        idle_pct = 0;
        src_gap = 0;
        sink_gap = 0;
        err_cnt = 0;
        wheel_factor_q15 = RST_WHEEL_FACTOR;
        follow_gain_q8 = RST_FOLLOW_GAIN;
        rotate_spin = RST_SPIN_RATE;
        fill_sine_lut();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests on the reset register values
        idle_pct = 25;
        add_req(MODE_ZERO_FORCE, '0, '0, '0, '0);
        add_req(MODE_NO_FOLLOW, SPEED_MAX, '0, 12345, '0);
        add_req(MODE_NO_FOLLOW, SPEED_MIN, SPEED_MIN, SPIN_MAX, '0);
        add_req(MODE_FREE_SPIN, SPEED_MAX, SPEED_MAX, SPIN_MIN, '0);
        add_req(MODE_FREE_SPIN, SPEED_MIN, SPEED_MAX, SPIN_MAX, QUARTER_TURN / 2);
        add_req(MODE_ZERO_FORCE, SPEED_MAX, SPEED_MIN, SPIN_MIN, HALF_TURN);
        add_req(MODE_FOLLOW, 1000, -1000, SPIN_MAX, HALF_TURN);
        add_req(MODE_FOLLOW, -1000, 1000, SPIN_MIN, -HALF_TURN);
        add_req(MODE_FOLLOW, 500, 500, 777, 1);
        add_req(MODE_FOLLOW, -500, 500, -777, -1);
        add_req(MODE_FOLLOW, SPEED_MAX, SPEED_MAX, '0, ANGLE_MIN);
        add_req(MODE_FOLLOW, SPEED_MIN, SPEED_MIN, '0, ANGLE_MAX);
        add_req(MODE_ROTATE, 20000, -15000, SPIN_MIN, QUARTER_TURN);
        add_req(MODE_ROTATE, -20000, 15000, SPIN_MAX, -QUARTER_TURN);
        add_req(MODE_FREE_SPIN + 1, 3000, 4000, -300, 100);
        add_req(MODE_LAST_CODE - 1, -3000, 4000, 300, -100);
        add_req(MODE_LAST_CODE, 3000, -4000, SPIN_MAX, 2000);
        add_req(MODE_FREE_SPIN, 12000, 9000, 50, 3000);
        add_req(MODE_FREE_SPIN, -12000, 9000, -50, -3000);
        add_req(MODE_NO_FOLLOW, 16000, 8000, '0, 2);
        add_req(MODE_FREE_SPIN, SPEED_MAX, SPEED_MAX, SPIN_MAX, -QUARTER_TURN / 2);
        add_req(MODE_NO_FOLLOW, SPEED_MAX, SPEED_MIN, '0, QUARTER_TURN / 2);

        run_phase(RST_WHEEL_FACTOR, RST_FOLLOW_GAIN, RST_SPIN_RATE, 20);
        run_phase(16'd23170, '1, SPIN_MIN, 50);
        run_phase('0, '0, SPIN_MAX, 10);
        run_phase(FACTOR_W'($urandom), GAIN_W'($urandom), SPIN_W'($urandom), 35);
        run_phase('1, 16'd256, '0, 30);
        // last stretch at full rate on both sides
        run_phase(RST_WHEEL_FACTOR, 16'd1000, -17'sd4000, 0);
        wait_drain();

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
